// ----- design/psg_pkg.sv -----
// Package for the four-voice tone and noise sample generator.
// Holds widths, step constants, operation and register codes, the amplitude ROM
// and the control structs passed from the top level to the voice modules.
package psg_pkg;

  localparam int CLOCK_STEP   = 6;
  localparam int FILTER_SHIFT = 3;

  localparam int RELOAD_W = 16;
  localparam int AMP_W    = 29;
  localparam int LEVEL_W  = 30;
  localparam int ACC_W    = 32;
  localparam int SAMPLE_W = 16;
  localparam int NCNT_W   = 4;
  localparam int MODE_W   = 3;
  localparam int LFSR_W   = 16;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic REG_CHAN0_IS_TONE = 1'b0;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h8000;

  typedef logic signed [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic                tick;
    logic                wr;
    logic [RELOAD_W-1:0] reload;
    logic [AMP_W-1:0]    amp;
  } voice_ctl_t;

  typedef struct packed {
    logic              tick;
    logic              wr;
    logic [MODE_W-1:0] mode;
    logic [AMP_W-1:0]  amp;
  } noise_ctl_t;

  localparam logic [31:0] AMP_ROM [128] = '{
    32'h00000000, 32'h00D9F772, 32'h00E054D2, 32'h00E6E1C6,
    32'h00ED9FB1, 32'h00F49002, 32'h00FBB432, 32'h01030DC4,
    32'h010A9E48, 32'h01126758, 32'h011A6A9A, 32'h0122A9C2,
    32'h012B2690, 32'h0133E2D0, 32'h013CE05E, 32'h0146211F,
    32'h014FA70D, 32'h0159742A, 32'h01638A8C, 32'h016DEC56,
    32'h01789BBC, 32'h01839B02, 32'h018EEC7D, 32'h019A9294,
    32'h01A68FBF, 32'h01B2E689, 32'h01BF9990, 32'h01CCAB85,
    32'h01DA1F2F, 32'h01E7F767, 32'h01F6371E, 32'h0204E158,
    32'h0213F932, 32'h022381E0, 32'h02337EAD, 32'h0243F2FD,
    32'h0254E24E, 32'h02665036, 32'h02784069, 32'h028AB6B4,
    32'h029DB701, 32'h02B14559, 32'h02C565E1, 32'h02DA1CDE,
    32'h02EF6EB4, 32'h03055FEA, 32'h031BF526, 32'h03333333,
    32'h034B1EFE, 32'h0363BD9B, 32'h037D1442, 32'h03972852,
    32'h03B1FF55, 32'h03CD9EFB, 32'h03EA0D20, 32'h04074FCB,
    32'h04256D31, 32'h04446BB6, 32'h046451EC, 32'h04852697,
    32'h04A6F0AE, 32'h04C9B75B, 32'h04ED81FF, 32'h05125831,
    32'h053841C0, 32'h055F46B8, 32'h05876F5E, 32'h05B0C438,
    32'h05DB4E09, 32'h060715D8, 32'h063424EC, 32'h066284D5,
    32'h06923F69, 32'h06C35EC6, 32'h06F5ED59, 32'h0729F5D9,
    32'h075F8351, 32'h0796A11C, 32'h07CF5AEA, 32'h0809BCC3,
    32'h0845D30A, 32'h0883AA7C, 32'h08C35038, 32'h0904D1BD,
    32'h09483CEF, 32'h098DA01C, 32'h09D509FB, 32'h0A1E89B0,
    32'h0A6A2ED4, 32'h0AB80970, 32'h0B082A08, 32'h0B5AA19B,
    32'h0BAF81A6, 32'h0C06DC29, 32'h0C60C3AC, 32'h0CBD4B3F,
    32'h0D1C8683, 32'h0D7E89A9, 32'h0DE3697D, 32'h0E4B3B63,
    32'h0EB6155F, 32'h0F240E1B, 32'h0F953CEA, 32'h1009B9CE,
    32'h10819D7B, 32'h10FD015F, 32'h117BFFA4, 32'h11FEB33B,
    32'h128537DB, 32'h130FAA0D, 32'h139E272D, 32'h1430CD74,
    32'h14C7BBFC, 32'h156312C7, 32'h1602F2C9, 32'h16A77DEA,
    32'h1750D70F, 32'h17FF2223, 32'h18B2841E, 32'h196B230B,
    32'h1A292612, 32'h1AECB580, 32'h1BB5FACF, 32'h1C8520AF,
    32'h1D5A530F, 32'h1E35BF26, 32'h1F17937F, 32'h1FFFFFFF
  };

  function automatic logic [AMP_W-1:0] amp_lookup(input logic [6:0] idx);
    logic [31:0] word;
    word = AMP_ROM[idx];
    return word[AMP_W-1:0];
  endfunction

endpackage

// ----- design/psg_tone_voice.sv -----
// One square-wave tone voice: down-counter, reload, amplitude and output level.
// Uses psg_pkg for widths, the step size and the voice control struct.
module psg_tone_voice (
  input  logic               clk,
  input  logic               rst_n,
  input  psg_pkg::voice_ctl_t ctl,
  output psg_pkg::level_t    level_nxt,
  output logic               toggled
);

  logic [psg_pkg::RELOAD_W-1:0] cnt_r, cnt_nxt;
  logic [psg_pkg::RELOAD_W-1:0] reload_r;
  logic [psg_pkg::AMP_W-1:0]    amp_r;
  psg_pkg::level_t              level_r;
  logic [psg_pkg::RELOAD_W:0]   diff;
  psg_pkg::level_t              amp_pos;

  assign diff    = {1'b0, cnt_r} - (psg_pkg::RELOAD_W+1)'(psg_pkg::CLOCK_STEP);
  assign amp_pos = psg_pkg::level_t'({1'b0, amp_r});
  assign toggled = ctl.tick && diff[psg_pkg::RELOAD_W];

  always_comb begin
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    if (ctl.tick) begin
      if (diff[psg_pkg::RELOAD_W]) begin
        cnt_nxt = reload_r;
        if (!level_r[psg_pkg::LEVEL_W-1] && (level_r != '0)) begin
          level_nxt = -amp_pos;
        end else begin
          level_nxt = amp_pos;
        end
      end else begin
        cnt_nxt = diff[psg_pkg::RELOAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      reload_r <= '0;
      amp_r    <= '0;
      level_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      level_r <= level_nxt;
      if (ctl.wr) begin
        reload_r <= ctl.reload;
        amp_r    <= ctl.amp;
      end
    end
  end

endmodule

// ----- design/psg_noise_gen.sv -----
// Noise voice: rate counter, 16-bit shift register and output level.
// Uses psg_pkg for widths, the step size, the seed and the noise control struct.
module psg_noise_gen (
  input  logic               clk,
  input  logic               rst_n,
  input  psg_pkg::noise_ctl_t ctl,
  input  logic               ch3_toggled,
  output psg_pkg::level_t    level_nxt
);

  localparam int DIFF_W = psg_pkg::NCNT_W + 3;

  logic [psg_pkg::NCNT_W-1:0] cnt_r, cnt_nxt;
  logic [psg_pkg::MODE_W-1:0] mode_r;
  logic [psg_pkg::LFSR_W-1:0] lfsr_r, lfsr_nxt, lfsr_src;
  logic [psg_pkg::AMP_W-1:0]  amp_r;
  psg_pkg::level_t            level_r;
  logic [DIFF_W-1:0]          diff;
  logic                       advance;
  logic                       top_bit;
  psg_pkg::level_t            amp_pos;

  assign diff     = {3'b000, cnt_r} - DIFF_W'(psg_pkg::CLOCK_STEP);
  assign amp_pos  = psg_pkg::level_t'({1'b0, amp_r});
  assign lfsr_src = (lfsr_r == '0) ? psg_pkg::LFSR_SEED : lfsr_r;
  assign top_bit  = lfsr_src[0] ^ (mode_r[2] & lfsr_src[3]);

  always_comb begin
    cnt_nxt = cnt_r;
    advance = 1'b0;
    if (ctl.tick) begin
      if (mode_r[1:0] == 2'b11) begin
        advance = ch3_toggled;
      end else if (diff[DIFF_W-1]) begin
        advance = 1'b1;
        cnt_nxt = psg_pkg::NCNT_W'(2) << mode_r[1:0];
      end else begin
        cnt_nxt = diff[psg_pkg::NCNT_W-1:0];
      end
    end
  end

  always_comb begin
    lfsr_nxt  = lfsr_r;
    level_nxt = level_r;
    if (advance) begin
      lfsr_nxt  = {top_bit, lfsr_src[psg_pkg::LFSR_W-1:1]};
      level_nxt = lfsr_src[1] ? amp_pos : -amp_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      mode_r  <= '0;
      lfsr_r  <= psg_pkg::LFSR_SEED;
      amp_r   <= '0;
      level_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      lfsr_r  <= lfsr_nxt;
      level_r <= level_nxt;
      if (ctl.wr) begin
        mode_r <= ctl.mode;
        amp_r  <= ctl.amp;
      end
    end
  end

endmodule

// ----- design/psg_mix_filter.sv -----
// Four-voice mixer and one-pole low-pass filter with its accumulator.
// Uses psg_pkg for the level type, widths and the filter shift.
module psg_mix_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           tick,
  input  psg_pkg::level_t                lvl0,
  input  psg_pkg::level_t                lvl1,
  input  psg_pkg::level_t                lvl2,
  input  psg_pkg::level_t                lvl3,
  output logic [psg_pkg::SAMPLE_W-1:0]   sample_nxt
);

  logic signed [psg_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [psg_pkg::ACC_W-1:0] sum;
  logic signed [psg_pkg::ACC_W:0]   delta;
  logic signed [psg_pkg::ACC_W:0]   step;
  logic signed [psg_pkg::ACC_W:0]   acc_wide;

  assign sum = psg_pkg::ACC_W'(lvl0) + psg_pkg::ACC_W'(lvl1)
             + psg_pkg::ACC_W'(lvl2) + psg_pkg::ACC_W'(lvl3);
  assign delta      = (psg_pkg::ACC_W+1)'(sum) - (psg_pkg::ACC_W+1)'(acc_r);
  assign step       = delta >>> psg_pkg::FILTER_SHIFT;
  assign acc_wide   = (psg_pkg::ACC_W+1)'(acc_r) + step;
  assign acc_nxt    = acc_wide[psg_pkg::ACC_W-1:0];
  assign sample_nxt = acc_nxt[psg_pkg::ACC_W-1 -: psg_pkg::SAMPLE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (tick) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ----- design/psg_tone_noise_sample_generator_unit.sv -----
// Top level of the four-voice tone and noise sample generator.
// Instantiates psg_tone_voice, psg_noise_gen and psg_mix_filter; uses psg_pkg.
//
// Usage: each input beat is either a tick (in_op low) or a settings write to
// channel in_chan (in_op high). A write loads a divider reload and an amplitude
// index, or, for channel 0 while it is the noise voice, a noise mode in the low
// three bits of in_tone_value. A write gives no output beat; each tick gives
// exactly one output beat carrying the filtered sample.
// The register chan0_is_tone at byte address 0 of the APB port selects whether
// channel 0 is a tone voice or the noise voice; change it only while idle.
// A tick is captured in the input register, processed by the voice update and
// the filter, and its sample is registered in the output register on out_sample.
// One beat is taken per cycle while the output is not stalled; the voice
// update between the input register and the output register is combinational.
// When the receiver stalls, the output register holds its sample, one more
// tick is held in the input register and in_stall rises; writes behind a
// stalled sample still drain. Reset clears all voices and the filter, seeds
// the noise shift register and leaves both channels empty.
module psg_tone_noise_sample_generator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [1:0]                   in_chan,
  input  logic [15:0]                  in_tone_value,
  input  logic [6:0]                   in_amp_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [15:0]           out_sample,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic        chan0_is_tone_r;
  logic        stg_valid_r, stg_valid_nxt;
  logic        stg_op_r;
  logic [1:0]  stg_chan_r;
  logic [15:0] stg_tone_value_r;
  logic [6:0]  stg_amp_index_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_sample_r;

  logic        out_free;
  logic        stg_go;
  logic        tick;
  logic        wr;
  logic        in_take;
  logic        cfg_wr;
  logic [psg_pkg::AMP_W-1:0] amp_val;

  psg_pkg::voice_ctl_t vctl [4];
  psg_pkg::noise_ctl_t nctl;
  psg_pkg::level_t     tone_lvl [4];
  psg_pkg::level_t     noise_lvl;
  psg_pkg::level_t     lvl0;
  logic [3:0]          tone_tgl;
  logic [15:0]         sample_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == psg_pkg::REG_CHAN0_IS_TONE);
  assign prdata = (paddr[2] == psg_pkg::REG_CHAN0_IS_TONE) ? {31'b0, chan0_is_tone_r} : '0;

  assign out_free = !out_valid_r || !out_stall;
  assign stg_go   = stg_valid_r && ((stg_op_r == psg_pkg::OP_WRITE) || out_free);
  assign tick     = stg_go && (stg_op_r == psg_pkg::OP_TICK);
  assign wr       = stg_go && (stg_op_r == psg_pkg::OP_WRITE);
  assign in_stall = stg_valid_r && !stg_go;
  assign in_take  = in_valid && !in_stall;
  assign amp_val  = psg_pkg::amp_lookup(stg_amp_index_r);

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_take) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_go) begin
      stg_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (tick) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vctl[i].tick   = tick && ((i != 0) || chan0_is_tone_r);
      vctl[i].wr     = wr && (stg_chan_r == 2'(i)) && ((i != 0) || chan0_is_tone_r);
      vctl[i].reload = stg_tone_value_r;
      vctl[i].amp    = amp_val;
    end
    nctl.tick = tick && !chan0_is_tone_r;
    nctl.wr   = wr && (stg_chan_r == 2'd0) && !chan0_is_tone_r;
    nctl.mode = stg_tone_value_r[psg_pkg::MODE_W-1:0];
    nctl.amp  = amp_val;
  end

  for (genvar g = 0; g < 4; g++) begin : g_voice
    psg_tone_voice u_voice (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (vctl[g]),
      .level_nxt (tone_lvl[g]),
      .toggled   (tone_tgl[g])
    );
  end

  psg_noise_gen u_noise (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (nctl),
    .ch3_toggled (tone_tgl[3]),
    .level_nxt   (noise_lvl)
  );

  assign lvl0 = chan0_is_tone_r ? tone_lvl[0] : noise_lvl;

  psg_mix_filter u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .lvl0       (lvl0),
    .lvl1       (tone_lvl[1]),
    .lvl2       (tone_lvl[2]),
    .lvl3       (tone_lvl[3]),
    .sample_nxt (sample_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan0_is_tone_r <= 1'b0;
      stg_valid_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        chan0_is_tone_r <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_op_r         <= in_op;
      stg_chan_r       <= in_chan;
      stg_tone_value_r <= in_tone_value;
      stg_amp_index_r  <= in_amp_index;
    end
    if (tick) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  logic unused_ok;
  assign unused_ok = ^{paddr[1:0], pwdata[31:1], tone_tgl[2:0]};

endmodule
